// File: sv/min_jerk_trajectory_3axis_unit_defines.svh
// assertion macros for the minimum-jerk trajectory unit
`ifndef MIN_JERK_TRAJECTORY_3AXIS_UNIT_DEFINES_SVH
`define MIN_JERK_TRAJECTORY_3AXIS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define MJT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mjt: property violated");
// condition must never be seen at a clock edge out of reset
`define MJT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mjt: forbidden condition seen");
`else
`define MJT_ASSERT(label, clk, rst_n, prop)
`define MJT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: sv/mjt_pkg.sv
// shared types and constants of the minimum-jerk trajectory unit
package mjt_pkg;

  // default parameter values
  localparam int TIME_WIDTH_DEF      = 32;
  localparam int PHASE_FRAC_BITS_DEF = 24;

  // field widths
  localparam int TIME_IN_W = 32;
  localparam int POS_W     = 32;
  localparam int VEL_W     = 35;
  localparam int ACC_W     = 36;
  localparam int DUR_W     = 32;
  localparam int DATA_W    = 32;
  localparam int MUL_A_W   = 32;
  localparam int NUM_AXES  = 3;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DUR_W-1:0] DUR_RESET = 32'd3000000;

  // register map indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd6;

  // configuration register contents
  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] start_pos;
    logic [NUM_AXES-1:0][POS_W-1:0] end_pos;
    logic [DUR_W-1:0]               duration;
  } cfg_t;

  // control of the shared multiplier
  typedef struct packed {
    logic start;
    logic round;
  } mul_req_t;

endpackage

// File: sv/mjt_cfg_regs.sv
// apb configuration registers of the minimum-jerk trajectory unit
module mjt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mjt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mjt_pkg::DATA_W-1:0]      pwdata,
  output logic [mjt_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output mjt_pkg::cfg_t                   cfg_o
);
  import mjt_pkg::*;

  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;
  cfg_t                 cfg_q;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pos <= '0;
      cfg_q.end_pos   <= '0;
      cfg_q.duration  <= DUR_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_START_X:  cfg_q.start_pos[0] <= pwdata;
        REG_START_Y:  cfg_q.start_pos[1] <= pwdata;
        REG_START_Z:  cfg_q.start_pos[2] <= pwdata;
        REG_END_X:    cfg_q.end_pos[0]   <= pwdata;
        REG_END_Y:    cfg_q.end_pos[1]   <= pwdata;
        REG_END_Z:    cfg_q.end_pos[2]   <= pwdata;
        REG_DURATION: cfg_q.duration     <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_START_X:  prdata = cfg_q.start_pos[0];
      REG_START_Y:  prdata = cfg_q.start_pos[1];
      REG_START_Z:  prdata = cfg_q.start_pos[2];
      REG_END_X:    prdata = cfg_q.end_pos[0];
      REG_END_Y:    prdata = cfg_q.end_pos[1];
      REG_END_Z:    prdata = cfg_q.end_pos[2];
      REG_DURATION: prdata = cfg_q.duration;
      default:      prdata = '0;
    endcase
  end

endmodule

// File: sv/mjt_divider.sv
// restoring divider producing the fractional phase one bit per cycle
module mjt_divider #(
  parameter int FracBits = mjt_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mjt_pkg::DUR_W-1:0]  dividend_i,
  input  logic [mjt_pkg::DUR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [FracBits-1:0]        quot_o
);
  import mjt_pkg::*;

  localparam int CntW = $clog2(FracBits + 1);
  localparam int RemW = DUR_W + 1;

  logic [CntW-1:0]     cnt_q;
  logic                done_q;
  logic [DUR_W-1:0]    rem_q;
  logic [FracBits-1:0] quot_q;
  logic [RemW-1:0]     rem_sh;
  logic [RemW-1:0]     rem_sub;
  logic                q_bit;

  // one trial subtraction per cycle
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - RemW'(divisor_i);
  assign q_bit   = (rem_sh >= RemW'(divisor_i));

  assign done_o = done_q;
  assign quot_o = quot_q;

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(FracBits);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= q_bit ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
      quot_q <= {quot_q[FracBits-2:0], q_bit};
    end
  end

endmodule

// File: sv/mjt_mul.sv
// shared unsigned multiplier, two partial products accumulated in successive passes
module mjt_mul #(
  parameter int FracBits = mjt_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mjt_pkg::mul_req_t                     req_i,
  input  logic [mjt_pkg::MUL_A_W-1:0]           a_i,
  input  logic [FracBits+2:0]                   b_i,
  output logic                                  done_o,
  output logic [mjt_pkg::MUL_A_W+FracBits+2:0]  prod_o
);
  import mjt_pkg::*;

  localparam int MagW  = FracBits + 3;
  localparam int HalfW = (MagW + 1) / 2;
  localparam int ProdW = MUL_A_W + MagW;
  localparam int PpW   = MUL_A_W + HalfW;
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (FracBits - 1);

  logic               busy_q;
  logic               hi_q;
  logic               done_q;
  logic [MUL_A_W-1:0] a_q;
  logic [MagW-1:0]    b_q;
  logic [ProdW-1:0]   acc_q;
  logic [HalfW-1:0]   chunk;
  logic [PpW-1:0]     pp;
  logic [ProdW-1:0]   pp_sh;

  // low half of b first, then the high half
  assign chunk = hi_q ? HalfW'(b_q[MagW-1:HalfW]) : b_q[HalfW-1:0];
  assign pp    = PpW'(a_q) * PpW'(chunk);
  assign pp_sh = hi_q ? (ProdW'(pp) << HalfW) : ProdW'(pp);

  assign done_o = done_q;
  assign prod_o = acc_q;

  // pass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hi_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      hi_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (hi_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        hi_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operands and accumulator, preloaded with the rounding half when asked
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= req_i.round ? RoundHalf : '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

endmodule

// File: sv/min_jerk_trajectory_3axis_unit.sv
// top level of the three-axis minimum-jerk setpoint generator
// Each request carries a time stamp and a restart bit and returns one result with
// position, velocity and acceleration for x, y and z plus a finished flag. The
// first request after reset, or one with restart set, takes its stamp as start
// time. The unit works on one request at a time: a request whose phase has
// reached one goes from acceptance through the prep and check states straight
// to the write state; any other also waits for the restoring divider that yields
// one phase bit per cycle and for the single shared multiplier, which needs two
// partial-product passes for each of the four phase powers and nine axis
// products. A new request is accepted as soon as the result is handed to the
// output register, even while that result waits. Configuration goes through the
// apb port with registers at byte address 4*i and may only be written while the
// unit is idle.
`include "min_jerk_trajectory_3axis_unit_defines.svh"

module min_jerk_trajectory_3axis_unit #(
  parameter int TIME_WIDTH      = mjt_pkg::TIME_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = mjt_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mjt_pkg::TIME_IN_W-1:0]       current_time_i,
  input  logic                                restart_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mjt_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [mjt_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [mjt_pkg::POS_W-1:0]    pos_z_o,
  output logic signed [mjt_pkg::VEL_W-1:0]    vel_x_o,
  output logic signed [mjt_pkg::VEL_W-1:0]    vel_y_o,
  output logic signed [mjt_pkg::VEL_W-1:0]    vel_z_o,
  output logic signed [mjt_pkg::ACC_W-1:0]    acc_x_o,
  output logic signed [mjt_pkg::ACC_W-1:0]    acc_y_o,
  output logic signed [mjt_pkg::ACC_W-1:0]    acc_z_o,
  output logic                                finished_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mjt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mjt_pkg::DATA_W-1:0]          pwdata,
  output logic [mjt_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import mjt_pkg::*;

  localparam int F        = PHASE_FRAC_BITS;
  localparam int StampW   = (TIME_WIDTH < TIME_IN_W) ? TIME_WIDTH : TIME_IN_W;
  localparam int MagW     = F + 3;
  localparam int PolyW    = F + 4;
  localparam int PolyExtW = F + 9;
  localparam int ProdW    = MUL_A_W + MagW;
  localparam int ResW     = MUL_A_W + 3;
  localparam int AlphaW   = POS_W + 1;
  localparam int AxisW    = $clog2(NUM_AXES);
  localparam logic [AxisW-1:0] LastAxis = AxisW'(NUM_AXES - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PREP      = 4'd1;
  localparam logic [3:0] ST_CHECK     = 4'd2;
  localparam logic [3:0] ST_DIV       = 4'd3;
  localparam logic [3:0] ST_POW_GO    = 4'd4;
  localparam logic [3:0] ST_POW_WAIT  = 4'd5;
  localparam logic [3:0] ST_POLY      = 4'd6;
  localparam logic [3:0] ST_ALPHA     = 4'd7;
  localparam logic [3:0] ST_PROD_GO   = 4'd8;
  localparam logic [3:0] ST_PROD_WAIT = 4'd9;
  localparam logic [3:0] ST_WRITE     = 4'd10;

  // which polynomial a product uses
  localparam logic [1:0] KIND_POS = 2'd0;
  localparam logic [1:0] KIND_VEL = 2'd1;
  localparam logic [1:0] KIND_ACC = 2'd2;

  // polynomial coefficients
  localparam logic signed [PolyExtW-1:0] K6   = PolyExtW'(6);
  localparam logic signed [PolyExtW-1:0] K10  = PolyExtW'(10);
  localparam logic signed [PolyExtW-1:0] K15  = PolyExtW'(15);
  localparam logic signed [PolyExtW-1:0] K30  = PolyExtW'(30);
  localparam logic signed [PolyExtW-1:0] K60  = PolyExtW'(60);
  localparam logic signed [PolyExtW-1:0] K120 = PolyExtW'(120);
  localparam logic signed [PolyExtW-1:0] K180 = PolyExtW'(180);
  localparam logic signed [PolyExtW-1:0] OneExt = PolyExtW'(1) << F;

  cfg_t cfg;

  // control state
  logic [3:0]        state_q, state_d;
  logic              awaiting_q;
  logic              done_q;
  logic [StampW-1:0] start_q;
  logic [2:0]        pidx_q;
  logic [AxisW-1:0]  axis_q;
  logic [1:0]        kind_q;
  logic              out_valid_q;

  // working registers
  logic [StampW-1:0] now_q;
  logic              restart_q;
  logic [StampW-1:0] elapsed_q;
  logic [F-1:0]      pw_q [5];
  logic [PolyW-1:0]  poly_q [3];
  logic [AlphaW-1:0] alpha_q;
  logic              neg_q;
  logic [POS_W-1:0]  pos_s_q [NUM_AXES];
  logic [VEL_W-1:0]  vel_s_q [NUM_AXES];
  logic [ACC_W-1:0]  acc_s_q [NUM_AXES];
  logic [POS_W-1:0]  out_pos_q [NUM_AXES];
  logic [VEL_W-1:0]  out_vel_q [NUM_AXES];
  logic [ACC_W-1:0]  out_acc_q [NUM_AXES];
  logic              out_fin_q;

  // datapath wires
  logic                       rearm;
  logic [StampW-1:0]          start_eff;
  logic [StampW:0]            elapsed_diff;
  logic                       finish_now;
  logic                       last_pow;
  logic                       out_free;
  logic                       out_fire;
  logic                       div_start;
  logic                       div_done;
  logic [F-1:0]               div_quot;
  mul_req_t                   mul_req;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MagW-1:0]            mul_b;
  logic                       mul_done;
  logic [ProdW-1:0]           mul_prod;
  logic [AlphaW-1:0]          alpha_abs;
  logic [PolyW-1:0]           poly_sel;
  logic [PolyW-1:0]           poly_abs;
  logic [ResW-1:0]            res_mag;
  logic [POS_W-1:0]           st_sel;
  logic signed [PolyExtW-1:0] e1, e2, e3, e4, e5;
  logic signed [PolyExtW-1:0] s_raw, s_clamp, v_raw, a_raw;

  mjt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mjt_divider #(.FracBits(F)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DUR_W'(elapsed_q)),
    .divisor_i  (cfg.duration),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  mjt_mul #(.FracBits(F)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_fire    = out_valid_q && !out_stall_i;

  // elapsed time, clamped at zero
  assign rearm        = awaiting_q || restart_q;
  assign start_eff    = rearm ? now_q : start_q;
  assign elapsed_diff = {1'b0, now_q} - {1'b0, start_eff};
  assign finish_now   = (DUR_W'(elapsed_q) >= cfg.duration);
  assign div_start    = (state_q == ST_CHECK) && !finish_now;
  assign last_pow     = (pidx_q == 3'd4);

  // phase polynomials
  assign e1 = $signed(PolyExtW'(pw_q[0]));
  assign e2 = $signed(PolyExtW'(pw_q[1]));
  assign e3 = $signed(PolyExtW'(pw_q[2]));
  assign e4 = $signed(PolyExtW'(pw_q[3]));
  assign e5 = $signed(PolyExtW'(pw_q[4]));
  assign s_raw = K10 * e3 - K15 * e4 + K6 * e5;
  assign v_raw = K30 * e2 - K60 * e3 + K30 * e4;
  assign a_raw = K60 * e1 - K180 * e2 + K120 * e3;
  assign s_clamp = (s_raw < 0) ? '0 : ((s_raw > OneExt) ? OneExt : s_raw);

  // multiplier operands: magnitudes of alpha and the selected polynomial
  assign alpha_abs = alpha_q[AlphaW-1] ? (AlphaW'(0) - alpha_q) : alpha_q;
  assign poly_sel  = poly_q[kind_q];
  assign poly_abs  = poly_sel[PolyW-1] ? (PolyW'(0) - poly_sel) : poly_sel;

  always_comb begin
    mul_req.start = (state_q == ST_POW_GO) || (state_q == ST_PROD_GO);
    mul_req.round = (state_q == ST_PROD_GO);
    if (state_q == ST_PROD_GO) begin
      mul_a = alpha_abs[MUL_A_W-1:0];
      mul_b = poly_abs[MagW-1:0];
    end else begin
      mul_a = MUL_A_W'(pw_q[0]);
      mul_b = MagW'(pw_q[pidx_q - 3'd1]);
    end
  end

  // rounded product magnitude and start position of the current axis
  assign res_mag = mul_prod[F +: ResW];
  assign st_sel  = cfg.start_pos[axis_q];

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_PREP;
      ST_PREP:      state_d = ST_CHECK;
      ST_CHECK:     state_d = finish_now ? ST_WRITE : ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_POW_GO;
      ST_POW_GO:    state_d = ST_POW_WAIT;
      ST_POW_WAIT: begin
        if (mul_done) state_d = last_pow ? ST_POLY : ST_POW_GO;
      end
      ST_POLY:      state_d = ST_ALPHA;
      ST_ALPHA:     state_d = ST_PROD_GO;
      ST_PROD_GO:   state_d = ST_PROD_WAIT;
      ST_PROD_WAIT: begin
        if (mul_done) begin
          if (kind_q == KIND_ACC) begin
            state_d = (axis_q == LastAxis) ? ST_WRITE : ST_ALPHA;
          end else begin
            state_d = ST_PROD_GO;
          end
        end
      end
      ST_WRITE:     if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      awaiting_q  <= 1'b1;
      done_q      <= 1'b0;
      start_q     <= '0;
      pidx_q      <= 3'd1;
      axis_q      <= '0;
      kind_q      <= KIND_POS;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // re-arm takes the stamp as start and clears the finish flag
      if (state_q == ST_PREP && rearm) begin
        start_q    <= now_q;
        awaiting_q <= 1'b0;
        done_q     <= 1'b0;
      end
      if (state_q == ST_CHECK && finish_now) begin
        done_q <= 1'b1;
      end
      // power counter
      if (state_q == ST_DIV && div_done) begin
        pidx_q <= 3'd1;
      end else if (state_q == ST_POW_WAIT && mul_done && !last_pow) begin
        pidx_q <= pidx_q + 3'd1;
      end
      // axis and product-kind counters
      if (state_q == ST_POLY) begin
        axis_q <= '0;
      end
      if (state_q == ST_ALPHA) begin
        kind_q <= KIND_POS;
      end
      if (state_q == ST_PROD_WAIT && mul_done) begin
        if (kind_q == KIND_ACC) begin
          axis_q <= axis_q + 1'b1;
        end else begin
          kind_q <= kind_q + 2'd1;
        end
      end
      // output register valid
      if (state_q == ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working data
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      now_q     <= current_time_i[StampW-1:0];
      restart_q <= restart_i;
    end
    if (state_q == ST_PREP) begin
      elapsed_q <= elapsed_diff[StampW] ? '0 : elapsed_diff[StampW-1:0];
    end
    // finished answer: end position, no motion
    if (state_q == ST_CHECK && finish_now) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pos_s_q[k] <= cfg.end_pos[k];
        vel_s_q[k] <= '0;
        acc_s_q[k] <= '0;
      end
    end
    // phase and its powers
    if (state_q == ST_DIV && div_done) begin
      pw_q[0] <= div_quot;
    end
    if (state_q == ST_POW_WAIT && mul_done) begin
      pw_q[pidx_q] <= mul_prod[2*F-1:F];
    end
    if (state_q == ST_POLY) begin
      poly_q[KIND_POS] <= s_clamp[PolyW-1:0];
      poly_q[KIND_VEL] <= v_raw[PolyW-1:0];
      poly_q[KIND_ACC] <= a_raw[PolyW-1:0];
    end
    // axis span end minus start
    if (state_q == ST_ALPHA) begin
      alpha_q <= {cfg.end_pos[axis_q][POS_W-1], cfg.end_pos[axis_q]}
               - {st_sel[POS_W-1], st_sel};
    end
    if (state_q == ST_PROD_GO) begin
      neg_q <= alpha_q[AlphaW-1] ^ poly_sel[PolyW-1];
    end
    // signed, rounded product into the result
    if (state_q == ST_PROD_WAIT && mul_done) begin
      case (kind_q)
        KIND_POS: begin
          pos_s_q[axis_q] <= neg_q ? (st_sel - res_mag[POS_W-1:0])
                                   : (st_sel + res_mag[POS_W-1:0]);
        end
        KIND_VEL: begin
          vel_s_q[axis_q] <= neg_q ? (VEL_W'(0) - VEL_W'(res_mag)) : VEL_W'(res_mag);
        end
        KIND_ACC: begin
          acc_s_q[axis_q] <= neg_q ? (ACC_W'(0) - ACC_W'(res_mag)) : ACC_W'(res_mag);
        end
        default: ;
      endcase
    end
    // hand the result to the output register
    if (state_q == ST_WRITE && out_free) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        out_pos_q[k] <= pos_s_q[k];
        out_vel_q[k] <= vel_s_q[k];
        out_acc_q[k] <= acc_s_q[k];
      end
      out_fin_q <= done_q;
    end
  end

  // result ports
  assign pos_x_o    = out_pos_q[0];
  assign pos_y_o    = out_pos_q[1];
  assign pos_z_o    = out_pos_q[2];
  assign vel_x_o    = out_vel_q[0];
  assign vel_y_o    = out_vel_q[1];
  assign vel_z_o    = out_vel_q[2];
  assign acc_x_o    = out_acc_q[0];
  assign acc_y_o    = out_acc_q[1];
  assign acc_z_o    = out_acc_q[2];
  assign finished_o = out_fin_q;

  // checks
  `MJT_ASSERT(a_accept_starts_prep, clk_i, rst_ni, in_valid_i && !in_stall_o |=> state_q == ST_PREP)
  `MJT_ASSERT(a_result_from_write, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_WRITE)
  `MJT_NEVER(a_mul_done_unexpected, clk_i, rst_ni, mul_done && state_q != ST_POW_WAIT && state_q != ST_PROD_WAIT)
  `MJT_ASSERT(a_armed_after_prep, clk_i, rst_ni, state_q == ST_CHECK |-> !awaiting_q)
  `MJT_ASSERT(a_finish_sets_flag, clk_i, rst_ni, state_q == ST_CHECK && finish_now |=> done_q)

endmodule
